// File: sv/vn2o_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn2o_pkg
// Shared types, constants and the cosine weight function of the 2D fractal
// value noise block.
// ----------------------------------------------------------------------------
package vn2o_pkg;

   localparam int COORD_W     = 32;
   localparam int OUT_W       = 20;
   localparam int REQ_DATA_W  = 64;
   localparam int RSP_DATA_W  = 24;
   localparam int CFG_W       = 4;
   localparam int CSR_IDX_W   = 1;
   localparam int OCT_W       = 3;
   localparam int SHIFT_W     = 4;
   localparam int AMT_W       = 7;
   // scaled coordinate: 32 bits shifted by up to seven, plus headroom
   localparam int VW          = COORD_W + 8;
   localparam int W_W         = 17;
   localparam int W_FRAC      = 16;
   localparam int Q_LEVEL_W   = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_OCTAVE_COUNT    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_AMPLITUDE_SHIFT = 1'd1;

   localparam logic [OCT_W-1:0]   OCTAVE_COUNT_RESET = 3'd2;
   localparam logic [SHIFT_W-1:0] AMP_SHIFT_RESET    = 4'd2;

   // integer hash constants
   localparam logic [31:0] HASH_ROW_MUL = 32'd57;
   localparam logic [31:0] HASH_SQ_MUL  = 32'd15731;
   localparam logic [31:0] HASH_ADD     = 32'd789221;
   localparam logic [31:0] HASH_OFS     = 32'd1376312589;

   // weight polynomial coefficients, Q30
   localparam longint COS_C0 = 64'sd2649351758;
   localparam longint COS_C1 = 64'sd2179004481;
   localparam longint COS_C2 = 64'sd716863740;
   localparam longint COS_C3 = 64'sd126342170;
   localparam longint COS_C4 = 64'sd13854969;
   localparam longint COS_C5 = 64'sd1035932;
   localparam longint Q30_ONE = 64'sd1073741824;
   localparam longint W_ONE   = 64'sd65536;

   // one queued point with its octave plan
   typedef struct packed {
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic [OCT_W-1:0]          last_idx;
      logic [SHIFT_W-1:0]        amp_shift;
   } job_type;

   // control that travels with one octave down the pipeline
   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last;
      logic [AMT_W-1:0] amt;
      logic [W_W-1:0]   wx;
      logic [W_W-1:0]   wy;
   } tag_type;

   // (1 - cos(pi t)) / 2 polynomial in t^2, Q30
   function automatic longint cos_poly(longint k, int tbits);
      longint s;
      longint p;
      s = (k * k) <<< (30 - 2 * tbits);
      p = -COS_C5;
      p = COS_C4 + ((p * s) >>> 30);
      p = -COS_C3 + ((p * s) >>> 30);
      p = COS_C2 + ((p * s) >>> 30);
      p = -COS_C1 + ((p * s) >>> 30);
      p = COS_C0 + ((p * s) >>> 30);
      return (p * s) >>> 30;
   endfunction

   // Q16 blend weight for table index k
   function automatic logic [W_W-1:0] cos_weight(int k, int tbits);
      longint full;
      longint kk;
      longint f;
      longint w;
      full = 64'sd1 <<< tbits;
      kk = k;
      if (kk > full) kk = full;
      if (2 * kk <= full) f = cos_poly(kk, tbits);
      else f = Q30_ONE - cos_poly(full - kk, tbits);
      w = (f + 64'sd8192) >>> 14;
      if (w < 0) w = 0;
      if (w > W_ONE) w = W_ONE;
      return W_W'(w);
   endfunction

endpackage

// File: sv/value_noise_2d_octaves.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_noise_2d_octaves
// Fractal 2D value noise: smoothed lattice hashes, cosine blended, summed
// over up to MAX_OCTAVES octaves with a programmable amplitude shift.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  req     | in  | req_tvalid/tready  | req_tdata: coord_x, coord_y
//  rsp     | out | rsp_tvalid/tready  | rsp_tdata: noise_value
//  csr     | in  | csr_we             | csr_index, csr_wdata
//
//  A point occupies the octave issue slot once per octave (octave count
//  clamped 1..MAX), and the next point is issued only after its last octave.
//  Reset clears control only; there are no memories to sweep.
//  While a result waits, the octave pipeline holds; the two-entry queue
//  keeps taking transfers until it fills.
// ----------------------------------------------------------------------------
module value_noise_2d_octaves import vn2o_pkg::*; #(
   parameter int FRAC_BITS      = 16,
   parameter int COS_TABLE_BITS = 8,
   parameter int MAX_OCTAVES    = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // coord_x [31:0], coord_y [63:32]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // noise_value [19:0], zero fill
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_wdata
);

   job_type                 f_job;
   logic                    f_valid;
   logic                    f_ready;
   logic                    q_valid;
   logic                    q_ready;
   logic [$bits(job_type)-1:0] q_data;
   logic [Q_LEVEL_W-1:0]    q_level;
   logic                    q_pop;
   logic signed [OUT_W-1:0] noise_value;

   // intake and control registers
   vn2o_front #(
      .MAX_OCTAVES (MAX_OCTAVES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .job_valid  (f_valid),
      .job_ready  (f_ready),
      .job_data   (f_job)
   );

   // queue between front and back
   vn2o_fifo #(
      .WIDTH ($bits(job_type))
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_job),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data),
      .level     (q_level)
   );

   // octave pipeline
   vn2o_back #(
      .FRAC_BITS      (FRAC_BITS),
      .COS_TABLE_BITS (COS_TABLE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (q_valid),
      .job_ready   (q_ready),
      .job_data    (job_type'(q_data)),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .noise_value (noise_value)
   );

   assign q_pop     = q_valid && q_ready;
   assign rsp_tdata = {{(RSP_DATA_W-OUT_W){1'b0}}, noise_value};

   // full queue must refuse transfers
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      q_level == 2'd2 |-> !req_tready)
      else $error("transfer offered while queue full");

   // no queue pop while the result register is stalled
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !q_pop)
      else $error("queue popped during output stall");

   // pop only from a non-empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_level != 2'd0)
      else $error("pop from empty queue");

   // no result straight after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

// File: sv/vn2o_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn2o_fifo
// Two-entry queue between the front and the back part.
// ----------------------------------------------------------------------------
module vn2o_fifo import vn2o_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [WIDTH-1:0]     in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [WIDTH-1:0]     out_data,
   output logic [Q_LEVEL_W-1:0] level
);

   logic [WIDTH-1:0]     mem_ff [2];
   logic                 wr_ptr_ff;
   logic                 rd_ptr_ff;
   logic [Q_LEVEL_W-1:0] level_ff;
   logic                 push;
   logic                 pop;

   assign in_ready  = (level_ff != 2'd2);
   assign out_valid = (level_ff != 2'd0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign level     = level_ff;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         if (push && !pop) level_ff <= level_ff + 2'd1;
         else if (pop && !push) level_ff <= level_ff - 2'd1;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= in_data;
   end

endmodule

// File: sv/vn2o_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn2o_front
// Control registers and intake: unpacks a point and attaches its octave plan.
// ----------------------------------------------------------------------------
module vn2o_front import vn2o_pkg::*; #(
   parameter int MAX_OCTAVES = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_wdata,
   output logic                  job_valid,
   input  logic                  job_ready,
   output job_type               job_data
);

   logic [OCT_W-1:0]   oct_count_ff;
   logic [SHIFT_W-1:0] amp_shift_ff;
   logic [OCT_W-1:0]   last_idx;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         oct_count_ff <= OCTAVE_COUNT_RESET;
         amp_shift_ff <= AMP_SHIFT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_OCTAVE_COUNT:    oct_count_ff <= csr_wdata[OCT_W-1:0];
            REG_AMPLITUDE_SHIFT: amp_shift_ff <= csr_wdata[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   // zero count acts as one octave, counts above the build limit saturate
   always_comb begin
      priority if (oct_count_ff == '0) begin
         last_idx = '0;
      end else if ({1'b0, oct_count_ff} > (OCT_W+1)'(MAX_OCTAVES)) begin
         last_idx = OCT_W'(MAX_OCTAVES - 1);
      end else begin
         last_idx = oct_count_ff - OCT_W'(1);
      end
   end

   // unpack the transfer into a queue entry
   assign job_data.coord_x   = req_tdata[COORD_W-1:0];
   assign job_data.coord_y   = req_tdata[2*COORD_W-1:COORD_W];
   assign job_data.last_idx  = last_idx;
   assign job_data.amp_shift = amp_shift_ff;
   assign job_valid          = req_tvalid;
   assign req_tready         = job_ready;

endmodule

// File: sv/vn2o_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn2o_hash
// One lattice hash lane: four pipelined stages from coordinate terms to the
// signed lattice value.
// ----------------------------------------------------------------------------
module vn2o_hash import vn2o_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        enable,
   input  logic [31:0]                 x_term,
   input  logic [31:0]                 y_term,
   output logic signed [FRAC_BITS+1:0] lattice_value
);

   localparam logic signed [FRAC_BITS+1:0] L_ONE = (FRAC_BITS+2)'(1) << FRAC_BITS;

   logic [31:0]                 sum;
   logic [31:0]                 mix;
   logic [31:0]                 hash;
   logic [31:0]                 n0_ff;
   logic [31:0]                 n1_ff;
   logic [31:0]                 n2_ff;
   logic [31:0]                 sq_ff;
   logic [31:0]                 t_ff;
   logic signed [FRAC_BITS+1:0] lat_ff;

   assign sum  = x_term + y_term;
   assign mix  = (sum << 13) ^ sum;
   assign hash = n2_ff * t_ff + HASH_OFS;

   // mix, square, polynomial, final product and scaling
   always_ff @(posedge clock) begin
      if (enable) begin
         n0_ff  <= mix;
         sq_ff  <= n0_ff * n0_ff;
         n1_ff  <= n0_ff;
         t_ff   <= sq_ff * HASH_SQ_MUL + HASH_ADD;
         n2_ff  <= n1_ff;
         lat_ff <= L_ONE - $signed({1'b0, hash[30:30-FRAC_BITS]});
      end
   end

   assign lattice_value = lat_ff;

endmodule

// File: sv/vn2o_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn2o_back
// Octave sequencer, octave pipeline, accumulator and result register.
// ----------------------------------------------------------------------------
module vn2o_back import vn2o_pkg::*; #(
   parameter int FRAC_BITS      = 16,
   parameter int COS_TABLE_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    job_valid,
   output logic                    job_ready,
   input  job_type                 job_data,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic signed [OUT_W-1:0] noise_value
);

   localparam int F      = FRAC_BITS;
   localparam int T      = COS_TABLE_BITS;
   localparam int SMW    = F + 2;
   localparam int SUMW   = F + 6;
   localparam int BW     = F + 3;
   localparam int DW     = BW + 1;
   localparam int PXW    = SMW + 1 + W_W + 1;
   localparam int PYW    = DW + W_W + 1;
   localparam int SW     = (BW + 4 > OUT_W + 1) ? BW + 4 : OUT_W + 1;
   localparam int LUT_N  = 1 << T;
   localparam int STAGES = 14;
   localparam logic signed [SW-1:0] SAT_HI = SW'((1 << (OUT_W - 1)) - 1);
   localparam logic signed [SW-1:0] SAT_LO = -SW'(1 << (OUT_W - 1));

   logic                      en;
   logic                      issue;
   logic                      last_oct;
   logic [OCT_W-1:0]          oct_idx_ff;
   tag_type                   tag_s1;
   tag_type                   tag_s4;
   tag_type                   tag_ff [1:STAGES];

   logic signed [COORD_W-1:0] cx_ff, cy_ff;
   logic [OCT_W-1:0]          idx_ff;
   logic signed [VW-1:0]      vx, vy;
   logic [VW-1:0]             mag_x_ff, mag_y_ff;
   logic                      neg_x_ff, neg_y_ff;
   logic [VW-1:0]             imag_x, imag_y;
   logic [F+T-1:0]            kfull_x, kfull_y;
   logic [31:0]               ix_ff, iy_ff;
   logic [T-1:0]              kx_ff, ky_ff;
   logic [W_W-1:0]            cos_lut [LUT_N];
   logic [31:0]               xx_ff [4];
   logic [31:0]               yy_ff [4];
   logic signed [SMW-1:0]     lat_w [4][4];
   logic signed [SUMW-1:0]    sum_w [2][2];
   logic signed [SMW-1:0]     sm_ff [2][2];
   logic signed [SMW:0]       d0, d1;
   logic signed [PXW-1:0]     px0_ff, px1_ff;
   logic signed [SMW-1:0]     a0_ff, a1_ff;
   logic signed [BW-1:0]      ra_ff, rb_ff, ra2_ff;
   logic signed [DW-1:0]      dy;
   logic signed [PYW-1:0]     py_ff;
   logic signed [BW-1:0]      ov_ff;
   logic signed [BW-1:0]      sv_ff;
   logic signed [SW-1:0]      acc_ff;
   logic signed [SW-1:0]      acc_in;
   logic signed [OUT_W-1:0]   sat_val;
   logic                      rsp_valid_ff;
   logic signed [OUT_W-1:0]   rsp_data_ff;

   // whole pipeline holds while a result waits
   assign en        = !rsp_valid_ff || rsp_tready;
   assign issue     = en && job_valid;
   assign last_oct  = (oct_idx_ff == job_data.last_idx);
   assign job_ready = issue && last_oct;

   // octave counter over the queue head
   always_ff @(posedge clock) begin
      if (reset) begin
         oct_idx_ff <= '0;
      end else if (issue) begin
         oct_idx_ff <= last_oct ? '0 : oct_idx_ff + OCT_W'(1);
      end
   end

   always_comb begin
      tag_s1.valid = issue;
      tag_s1.first = (oct_idx_ff == '0);
      tag_s1.last  = last_oct;
      tag_s1.amt   = AMT_W'(job_data.amp_shift) * AMT_W'(oct_idx_ff);
      tag_s1.wx    = '0;
      tag_s1.wy    = '0;
   end

   // blend weights join the tag at stage four
   always_comb begin
      tag_s4    = tag_ff[3];
      tag_s4.wx = cos_lut[kx_ff];
      tag_s4.wy = cos_lut[ky_ff];
   end

   // control tags, one per stage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= STAGES; k++) tag_ff[k] <= '0;
      end else if (en) begin
         tag_ff[1] <= tag_s1;
         for (int k = 2; k <= STAGES; k++) tag_ff[k] <= (k == 4) ? tag_s4 : tag_ff[k-1];
      end
   end

   // weight table
   for (genvar k = 0; k < LUT_N; k++) begin : g_lut
      localparam logic [W_W-1:0] WK = cos_weight(k, T);
      assign cos_lut[k] = WK;
   end

   // octave scaling and magnitude
   assign vx = VW'(cx_ff) <<< idx_ff;
   assign vy = VW'(cy_ff) <<< idx_ff;

   // integer part truncated toward zero, table index from the fraction
   assign imag_x  = mag_x_ff >> F;
   assign imag_y  = mag_y_ff >> F;
   assign kfull_x = {mag_x_ff[F-1:0], {T{1'b0}}};
   assign kfull_y = {mag_y_ff[F-1:0], {T{1'b0}}};

   always_ff @(posedge clock) begin
      if (en) begin
         // stage 1: captured point
         cx_ff    <= job_data.coord_x;
         cy_ff    <= job_data.coord_y;
         idx_ff   <= oct_idx_ff;
         // stage 2
         neg_x_ff <= cx_ff[COORD_W-1];
         neg_y_ff <= cy_ff[COORD_W-1];
         mag_x_ff <= cx_ff[COORD_W-1] ? VW'(-vx) : VW'(vx);
         mag_y_ff <= cy_ff[COORD_W-1] ? VW'(-vy) : VW'(vy);
         // stage 3
         ix_ff    <= neg_x_ff ? 32'(-imag_x) : imag_x[31:0];
         iy_ff    <= neg_y_ff ? 32'(-imag_y) : imag_y[31:0];
         kx_ff    <= kfull_x[F+T-1 -: T];
         ky_ff    <= kfull_y[F+T-1 -: T];
         // stage 4: lattice columns and scaled rows
         for (int c = 0; c < 4; c++) begin
            xx_ff[c] <= ix_ff + 32'(c) - 32'd1;
            yy_ff[c] <= (iy_ff + 32'(c) - 32'd1) * HASH_ROW_MUL;
         end
      end
   end

   // sixteen hash lanes, stages five to eight
   for (genvar r = 0; r < 4; r++) begin : g_row
      for (genvar c = 0; c < 4; c++) begin : g_col
         vn2o_hash #(
            .FRAC_BITS (F)
         ) u_hash (
            .clock         (clock),
            .enable        (en),
            .x_term        (xx_ff[c]),
            .y_term        (yy_ff[r]),
            .lattice_value (lat_w[r][c])
         );
      end
   end

   // 1-2-1 smoothing around the four cell corners
   for (genvar b = 0; b < 2; b++) begin : g_sb
      for (genvar a = 0; a < 2; a++) begin : g_sa
         assign sum_w[b][a] =
            SUMW'(lat_w[b][a]) + SUMW'(lat_w[b][a+2])
            + SUMW'(lat_w[b+2][a]) + SUMW'(lat_w[b+2][a+2])
            + ((SUMW'(lat_w[b+1][a]) + SUMW'(lat_w[b+1][a+2])
                + SUMW'(lat_w[b][a+1]) + SUMW'(lat_w[b+2][a+1])) <<< 1)
            + (SUMW'(lat_w[b+1][a+1]) <<< 2);
      end
   end

   // horizontal then vertical blend
   assign d0 = (SMW+1)'(sm_ff[0][1]) - (SMW+1)'(sm_ff[0][0]);
   assign d1 = (SMW+1)'(sm_ff[1][1]) - (SMW+1)'(sm_ff[1][0]);
   assign dy = DW'(rb_ff) - DW'(ra_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         // stage 9
         for (int b = 0; b < 2; b++) begin
            for (int a = 0; a < 2; a++) begin
               sm_ff[b][a] <= SMW'(sum_w[b][a] >>> 4);
            end
         end
         // stage 10
         px0_ff <= d0 * $signed({1'b0, tag_ff[9].wx});
         px1_ff <= d1 * $signed({1'b0, tag_ff[9].wx});
         a0_ff  <= sm_ff[0][0];
         a1_ff  <= sm_ff[1][0];
         // stage 11
         ra_ff  <= BW'(PXW'(a0_ff) + (px0_ff >>> W_FRAC));
         rb_ff  <= BW'(PXW'(a1_ff) + (px1_ff >>> W_FRAC));
         // stage 12
         py_ff  <= dy * $signed({1'b0, tag_ff[11].wy});
         ra2_ff <= ra_ff;
         // stage 13
         ov_ff  <= BW'(PYW'(ra2_ff) + (py_ff >>> W_FRAC));
         // stage 14: octave weight
         sv_ff  <= ov_ff >>> tag_ff[13].amt;
      end
   end

   // accumulate and saturate
   assign acc_in = tag_ff[STAGES].first ? SW'(sv_ff) : acc_ff + SW'(sv_ff);

   always_comb begin
      priority if (acc_in > SAT_HI) begin
         sat_val = SAT_HI[OUT_W-1:0];
      end else if (acc_in < SAT_LO) begin
         sat_val = SAT_LO[OUT_W-1:0];
      end else begin
         sat_val = acc_in[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en && tag_ff[STAGES].valid) acc_ff <= acc_in;
      if (en && tag_ff[STAGES].valid && tag_ff[STAGES].last) rsp_data_ff <= sat_val;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= tag_ff[STAGES].valid && tag_ff[STAGES].last;
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign noise_value = rsp_data_ff;

endmodule
